// ===== rtl/core/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants of the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned HUE_W  = 16;
	localparam int unsigned CH_W   = 9;
	localparam int unsigned FRAC_W = 13;
	localparam int unsigned SEC_W  = 3;

	localparam logic [HUE_W-1:0]  HUE_TURN     = 16'd46080;
	localparam logic [FRAC_W-1:0] FRAC_SPAN    = 13'd7680;
	localparam int unsigned       SECTOR_CODES = 7680;

	// 7680 = 15 * 2^9: divide by the power of two, then by 15 via reciprocal
	localparam int unsigned SECTOR_SH = 9;
	localparam int unsigned QUO_W     = 13;
	localparam int unsigned RECIP_W   = 14;
	localparam int unsigned RECIP_SH  = 17;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 14'd8739;

	localparam int unsigned PIPE_DEPTH = 7;

	typedef enum logic [SEC_W-1:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
		logic [CH_W-1:0]   sat;
		logic [CH_W-1:0]   val;
	} hsv_pos_t;

	typedef struct packed {
		sector_t         sector;
		logic            gray;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] p;
		logic [CH_W-1:0] q;
		logic [CH_W-1:0] t;
	} hsv_terms_t;

	function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
		logic [HUE_W-1:0] base;
		case (sec)
			SEC_R_Y: base = 16'd0;
			SEC_Y_G: base = 16'd7680;
			SEC_G_C: base = 16'd15360;
			SEC_C_B: base = 16'd23040;
			SEC_B_M: base = 16'd30720;
			SEC_M_R: base = 16'd38400;
			default: base = 16'd0;
		endcase
		return base;
	endfunction

endpackage

// ===== rtl/core/hsvrgb_if.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_if
// Valid/ready stream interfaces for HSV pixels in and RGB pixels out.
// ----------------------------------------------------------------------------
interface hsvrgb_hsv_if;
	logic                         valid;
	logic                         ready;
	logic [hsvrgb_pkg::HUE_W-1:0] hue;
	logic [hsvrgb_pkg::CH_W-1:0]  saturation;
	logic [hsvrgb_pkg::CH_W-1:0]  brightness;

	modport source(output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink(input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface hsvrgb_rgb_if;
	logic                        valid;
	logic                        ready;
	logic [hsvrgb_pkg::CH_W-1:0] red;
	logic [hsvrgb_pkg::CH_W-1:0] green;
	logic [hsvrgb_pkg::CH_W-1:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Throughput: one pixel per cycle while rgb is not stalled; seven register stages, three of them with multiplies
// (s*f and p products, value times the q/t numerators, reciprocal divide by 15).
// A stalled stage holds; empty stages further up keep taking pixels.
// Reset: arst_n clears all stage valid bits; payload registers keep data.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
	parameter int unsigned UNIT_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	hsvrgb_hsv_if.sink   hsv,
	hsvrgb_rgb_if.source rgb
);
	import hsvrgb_pkg::*;

	logic       pos_valid;
	logic       pos_ready;
	hsv_pos_t   pos;
	logic       trm_valid;
	logic       trm_ready;
	hsv_terms_t trm;

	hsvrgb_sector #(
		.UNIT_BITS(UNIT_BITS)
	) u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsv      (hsv),
		.pos_valid(pos_valid),
		.pos_ready(pos_ready),
		.pos      (pos)
	);

	hsvrgb_terms #(
		.UNIT_BITS(UNIT_BITS)
	) u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos_valid(pos_valid),
		.pos_ready(pos_ready),
		.pos      (pos),
		.trm_valid(trm_valid),
		.trm_ready(trm_ready),
		.trm      (trm)
	);

	hsvrgb_order u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.trm_valid(trm_valid),
		.trm_ready(trm_ready),
		.trm      (trm),
		.rgb      (rgb)
	);

endmodule

// ===== rtl/core/hsvrgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Stages 1-2: wrap hue, clamp saturation and value, split hue into sector
// and fraction within the sector.
// ----------------------------------------------------------------------------
module hsvrgb_sector #(
	parameter int unsigned UNIT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hsvrgb_hsv_if.sink           hsv,
	output logic                 pos_valid,
	input  logic                 pos_ready,
	output hsvrgb_pkg::hsv_pos_t pos
);
	import hsvrgb_pkg::*;

	localparam int unsigned ONE      = 1 << UNIT_BITS;
	localparam int unsigned CH_MAX   = (1 << CH_W) - 1;
	localparam logic [CH_W-1:0] UNIT_LIM = CH_W'((ONE > CH_MAX) ? CH_MAX : ONE);

	logic             vld_s1;
	logic             rdy_s1;
	logic [HUE_W-1:0] hue_s1;
	logic [CH_W-1:0]  sat_s1;
	logic [CH_W-1:0]  val_s1;
	logic             vld_s2;
	logic             rdy_s2;
	hsv_pos_t         pos_s2;
	logic [HUE_W-1:0] hue_wrap;
	sector_t          sec;

	assign rdy_s2    = !vld_s2 || pos_ready;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign hsv.ready = rdy_s1;
	assign pos_valid = vld_s2;
	assign pos       = pos_s2;

	assign hue_wrap = (hsv.hue >= HUE_TURN) ? (hsv.hue - HUE_TURN) : hsv.hue;

	always_comb begin
		if (hue_s1 >= sector_base(SEC_M_R)) begin
			sec = SEC_M_R;
		end else if (hue_s1 >= sector_base(SEC_B_M)) begin
			sec = SEC_B_M;
		end else if (hue_s1 >= sector_base(SEC_C_B)) begin
			sec = SEC_C_B;
		end else if (hue_s1 >= sector_base(SEC_G_C)) begin
			sec = SEC_G_C;
		end else if (hue_s1 >= sector_base(SEC_Y_G)) begin
			sec = SEC_Y_G;
		end else begin
			sec = SEC_R_Y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= hsv.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && hsv.valid) begin
			hue_s1 <= hue_wrap;
			sat_s1 <= (hsv.saturation > UNIT_LIM) ? UNIT_LIM : hsv.saturation;
			val_s1 <= (hsv.brightness > UNIT_LIM) ? UNIT_LIM : hsv.brightness;
		end
		if (rdy_s2 && vld_s1) begin
			pos_s2.sector <= sec;
			pos_s2.frac   <= FRAC_W'(hue_s1 - sector_base(sec));
			pos_s2.sat    <= sat_s1;
			pos_s2.val    <= val_s1;
		end
	end

endmodule

// ===== rtl/core/hsvrgb_terms.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_terms
// Stages 3-6: form p, q and t with truncating fixed-point multiplies.
// ----------------------------------------------------------------------------
module hsvrgb_terms #(
	parameter int unsigned UNIT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pos_valid,
	output logic                   pos_ready,
	input  hsvrgb_pkg::hsv_pos_t   pos,
	output logic                   trm_valid,
	input  logic                   trm_ready,
	output hsvrgb_pkg::hsv_terms_t trm
);
	import hsvrgb_pkg::*;

	localparam int unsigned ONE = 1 << UNIT_BITS;
	localparam int unsigned OW  = (UNIT_BITS + 1 > CH_W) ? UNIT_BITS + 1 : CH_W;
	localparam int unsigned DW  = UNIT_BITS + FRAC_W;
	localparam int unsigned PW  = CH_W + FRAC_W;
	localparam int unsigned SW  = (DW > PW) ? DW : PW;
	localparam int unsigned MW  = CH_W + DW;
	localparam int unsigned SH  = UNIT_BITS + SECTOR_SH;
	localparam int unsigned RW  = QUO_W + RECIP_W;
	localparam logic [DW-1:0] DEN = DW'(ONE * SECTOR_CODES);

	typedef struct packed {
		sector_t         sector;
		logic            gray;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] p;
	} side_t;

	logic             vld_s3, vld_s4, vld_s5, vld_s6;
	logic             rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	side_t            side_s3, side_s4, side_s5, side_s6;
	logic [PW-1:0]    sq_s3, st_s3;
	logic [DW-1:0]    dq_s4, dt_s4;
	logic [QUO_W-1:0] mq_s5, mt_s5;
	logic [CH_W-1:0]  q_s6, t_s6;

	logic [FRAC_W-1:0]  frac_rest;
	logic [OW-1:0]      one_minus_s;
	logic [CH_W+OW-1:0] pv;
	logic [MW-1:0]      mq, mt;
	logic [RW-1:0]      rq, rt;

	assign rdy_s6    = !vld_s6 || trm_ready;
	assign rdy_s5    = !vld_s5 || rdy_s6;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign pos_ready = rdy_s3;

	assign frac_rest   = FRAC_SPAN - pos.frac;
	assign one_minus_s = OW'(ONE) - OW'(pos.sat);
	assign pv          = (CH_W + OW)'(pos.val) * (CH_W + OW)'(one_minus_s);
	assign mq          = MW'(side_s4.val) * MW'(dq_s4);
	assign mt          = MW'(side_s4.val) * MW'(dt_s4);
	assign rq          = RW'(mq_s5) * RW'(RECIP_MUL);
	assign rt          = RW'(mt_s5) * RW'(RECIP_MUL);

	assign trm_valid  = vld_s6;
	assign trm.sector = side_s6.sector;
	assign trm.gray   = side_s6.gray;
	assign trm.val    = side_s6.val;
	assign trm.p      = side_s6.p;
	assign trm.q      = q_s6;
	assign trm.t      = t_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= pos_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && pos_valid) begin
			side_s3.sector <= pos.sector;
			side_s3.gray   <= (pos.sat == '0);
			side_s3.val    <= pos.val;
			side_s3.p      <= CH_W'(pv >> UNIT_BITS);
			sq_s3          <= PW'(pos.sat) * PW'(pos.frac);
			st_s3          <= PW'(pos.sat) * PW'(frac_rest);
		end
		if (rdy_s4 && vld_s3) begin
			side_s4 <= side_s3;
			dq_s4   <= DW'(SW'(DEN) - SW'(sq_s3));
			dt_s4   <= DW'(SW'(DEN) - SW'(st_s3));
		end
		if (rdy_s5 && vld_s4) begin
			side_s5 <= side_s4;
			mq_s5   <= QUO_W'(mq >> SH);
			mt_s5   <= QUO_W'(mt >> SH);
		end
		if (rdy_s6 && vld_s5) begin
			side_s6 <= side_s5;
			q_s6    <= CH_W'(rq >> RECIP_SH);
			t_s6    <= CH_W'(rt >> RECIP_SH);
		end
	end

endmodule

// ===== rtl/core/hsvrgb_order.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_order
// Stage 7: place v, p, q and t on red, green and blue by sector (v on all
// three when saturation is zero) and hold the result in the output register.
// ----------------------------------------------------------------------------
module hsvrgb_order (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   trm_valid,
	output logic                   trm_ready,
	input  hsvrgb_pkg::hsv_terms_t trm,
	hsvrgb_rgb_if.source           rgb
);
	import hsvrgb_pkg::*;

	logic            vld_q;
	logic [CH_W-1:0] red_q, green_q, blue_q;
	logic [CH_W-1:0] red_d, green_d, blue_d;

	assign trm_ready = !vld_q || rgb.ready;
	assign rgb.valid = vld_q;
	assign rgb.red   = red_q;
	assign rgb.green = green_q;
	assign rgb.blue  = blue_q;

	always_comb begin
		if (trm.gray) begin
			red_d   = trm.val;
			green_d = trm.val;
			blue_d  = trm.val;
		end else begin
			case (trm.sector)
				SEC_R_Y: begin
					red_d = trm.val; green_d = trm.t;   blue_d = trm.p;
				end
				SEC_Y_G: begin
					red_d = trm.q;   green_d = trm.val; blue_d = trm.p;
				end
				SEC_G_C: begin
					red_d = trm.p;   green_d = trm.val; blue_d = trm.t;
				end
				SEC_C_B: begin
					red_d = trm.p;   green_d = trm.q;   blue_d = trm.val;
				end
				SEC_B_M: begin
					red_d = trm.t;   green_d = trm.p;   blue_d = trm.val;
				end
				default: begin
					red_d = trm.val; green_d = trm.p;   blue_d = trm.q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (trm_ready) begin
			vld_q <= trm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (trm_ready && trm_valid) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

endmodule

// ===== rtl/core/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks of the converter: occupancy, output range, drain and
// output hold under stall.
// ----------------------------------------------------------------------------
module hsvrgb_checker #(
	parameter int unsigned UNIT_BITS = 8
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [hsvrgb_pkg::CH_W-1:0] red,
	input logic [hsvrgb_pkg::CH_W-1:0] green,
	input logic [hsvrgb_pkg::CH_W-1:0] blue
);
	import hsvrgb_pkg::*;

	localparam int unsigned ONE      = 1 << UNIT_BITS;
	localparam int unsigned CH_MAX   = (1 << CH_W) - 1;
	localparam logic [CH_W-1:0] UNIT_LIM = CH_W'((ONE > CH_MAX) ? CH_MAX : ONE);
	localparam int unsigned OCC_W    = $clog2(PIPE_DEPTH + 2);

	logic             in_xfer;
	logic             out_xfer;
	logic [OCC_W-1:0] occ_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_xfer) - OCC_W'(out_xfer);
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more pixels in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != '0))
		else $error("output valid with no pixel in flight");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= UNIT_LIM) && (green <= UNIT_LIM) && (blue <= UNIT_LIM))
		else $error("channel above full scale");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled output changed");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker #(
	.UNIT_BITS(UNIT_BITS)
) u_hsvrgb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (hsv.valid),
	.in_ready (hsv.ready),
	.out_valid(rgb.valid),
	.out_ready(rgb.ready),
	.red      (rgb.red),
	.green    (rgb.green),
	.blue     (rgb.blue)
);
